[rtl/core/aff2d_pkg.sv]
`timescale 1ns / 1ps
// aff2d_pkg: widths, register indexes and shared types of the 2d affine point transform.
// No dependencies; every other file of the block refers to it by scoped names.
package aff2d_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW        = 32;                  // coordinate and coefficient width
	localparam int IDXW      = 3;                   // register index width
	localparam int OPW       = CW + 1;              // point operand, holds x - offset_x
	localparam int PW        = OPW + CW;            // point times coefficient
	localparam int DPW       = 2 * CW;              // coefficient times coefficient
	localparam int SW        = PW + 1;              // sum of two products
	localparam int NW        = SW + FRAC_BITS;      // numerator
	localparam int DW        = DPW + 1;             // determinant
	localparam int QW        = CW + 1;              // quotient magnitude, top bit marks overflow
	localparam int RW        = ((NW > DW + QW - 1) ? NW : DW + QW - 1) + 1;
	localparam int NDIV      = QW;                  // one quotient bit per stage
	localparam int FRONT_ST  = 5;
	localparam int NST       = FRONT_ST + NDIV + 1;

	localparam logic [DW-1:0] DEN_ONE = DW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] COEF_ONE = CW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [IDXW-1:0] {
		REG_COEF_A   = 3'd0,
		REG_COEF_B   = 3'd1,
		REG_COEF_C   = 3'd2,
		REG_COEF_D   = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] coef_a;
		logic signed [CW-1:0] coef_b;
		logic signed [CW-1:0] coef_c;
		logic signed [CW-1:0] coef_d;
		logic signed [CW-1:0] offset_x;
		logic signed [CW-1:0] offset_y;
	} coef_t;

	// sideband that travels with the divider operands
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic sing;
	} tag_t;

endpackage

[rtl/core/aff2d_cfg.sv]
`timescale 1ns / 1ps
// aff2d_cfg: the six matrix and offset registers behind the configuration write channel.
// Depends on aff2d_pkg.
module aff2d_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [aff2d_pkg::IDXW-1:0]    cfg_index,
	input  logic [aff2d_pkg::CW-1:0]      cfg_data,
	output aff2d_pkg::coef_t              coef
);

	aff2d_pkg::coef_t coef_q;

	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.coef_a   <= aff2d_pkg::COEF_ONE;
			coef_q.coef_b   <= '0;
			coef_q.coef_c   <= '0;
			coef_q.coef_d   <= aff2d_pkg::COEF_ONE;
			coef_q.offset_x <= '0;
			coef_q.offset_y <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (aff2d_pkg::reg_idx_t'(cfg_index))
				aff2d_pkg::REG_COEF_A:   coef_q.coef_a   <= cfg_data;
				aff2d_pkg::REG_COEF_B:   coef_q.coef_b   <= cfg_data;
				aff2d_pkg::REG_COEF_C:   coef_q.coef_c   <= cfg_data;
				aff2d_pkg::REG_COEF_D:   coef_q.coef_d   <= cfg_data;
				aff2d_pkg::REG_OFFSET_X: coef_q.offset_x <= cfg_data;
				aff2d_pkg::REG_OFFSET_Y: coef_q.offset_y <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/aff2d_front.sv]
`timescale 1ns / 1ps
// aff2d_front: five stages that build numerators and denominator magnitudes for the divider.
// Depends on aff2d_pkg.
module aff2d_front (
	input  logic                                  clk,
	input  logic [aff2d_pkg::FRONT_ST-1:0]        en,
	input  aff2d_pkg::coef_t                      coef,
	input  logic                                  command,
	input  logic signed [aff2d_pkg::CW-1:0]       x_in,
	input  logic signed [aff2d_pkg::CW-1:0]       y_in,
	output logic [aff2d_pkg::NW-1:0]              un_x,
	output logic [aff2d_pkg::NW-1:0]              un_y,
	output logic [aff2d_pkg::DW-1:0]              ud,
	output aff2d_pkg::tag_t                       tag
);

	logic                                inv_s1, inv_s2, inv_s3, inv_s4;
	logic signed [aff2d_pkg::OPW-1:0]    opx_s1, opy_s1;
	logic signed [aff2d_pkg::PW-1:0]     p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [aff2d_pkg::DPW-1:0]    pa_s2, pb_s2;
	logic signed [aff2d_pkg::SW-1:0]     sx_s3, sy_s3;
	logic signed [aff2d_pkg::DW-1:0]     det_s3;
	logic signed [aff2d_pkg::NW-1:0]     nx_s4, ny_s4;
	logic signed [aff2d_pkg::DW-1:0]     den_s4;
	logic                                sing_s4;
	logic [aff2d_pkg::NW-1:0]            unx_s5, uny_s5;
	logic [aff2d_pkg::DW-1:0]            ud_s5;
	aff2d_pkg::tag_t                     tag_s5;

	logic signed [aff2d_pkg::CW-1:0]     ca, cb, cc, cd, m_x, m_y;
	logic signed [aff2d_pkg::NW-1:0]     ox_fx, oy_fx;

	always_comb begin
		ca    = coef.coef_a;
		cb    = coef.coef_b;
		cc    = coef.coef_c;
		cd    = coef.coef_d;
		// inverse uses the adjugate: d on x, a on y
		m_x   = inv_s1 ? cd : ca;
		m_y   = inv_s1 ? ca : cd;
		ox_fx = aff2d_pkg::NW'(coef.offset_x) <<< aff2d_pkg::FRAC_BITS;
		oy_fx = aff2d_pkg::NW'(coef.offset_y) <<< aff2d_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			inv_s1 <= command;
			if (command) begin
				opx_s1 <= {x_in[aff2d_pkg::CW-1], x_in} -
					{coef.offset_x[aff2d_pkg::CW-1], coef.offset_x};
				opy_s1 <= {y_in[aff2d_pkg::CW-1], y_in} -
					{coef.offset_y[aff2d_pkg::CW-1], coef.offset_y};
			end else begin
				opx_s1 <= {x_in[aff2d_pkg::CW-1], x_in};
				opy_s1 <= {y_in[aff2d_pkg::CW-1], y_in};
			end
		end
		if (en[1]) begin
			inv_s2 <= inv_s1;
			p0_s2  <= opx_s1 * m_x;
			p1_s2  <= opy_s1 * cc;
			p2_s2  <= opy_s1 * m_y;
			p3_s2  <= opx_s1 * cb;
			pa_s2  <= ca * cd;
			pb_s2  <= cc * cb;
		end
		if (en[2]) begin
			inv_s3 <= inv_s2;
			if (inv_s2) begin
				sx_s3 <= aff2d_pkg::SW'(p0_s2) - aff2d_pkg::SW'(p1_s2);
				sy_s3 <= aff2d_pkg::SW'(p2_s2) - aff2d_pkg::SW'(p3_s2);
			end else begin
				sx_s3 <= aff2d_pkg::SW'(p0_s2) + aff2d_pkg::SW'(p1_s2);
				sy_s3 <= aff2d_pkg::SW'(p2_s2) + aff2d_pkg::SW'(p3_s2);
			end
			det_s3 <= aff2d_pkg::DW'(pa_s2) - aff2d_pkg::DW'(pb_s2);
		end
		if (en[3]) begin
			inv_s4  <= inv_s3;
			sing_s4 <= inv_s3 && (det_s3 == '0);
			if (inv_s3) begin
				nx_s4  <= aff2d_pkg::NW'(sx_s3) <<< aff2d_pkg::FRAC_BITS;
				ny_s4  <= aff2d_pkg::NW'(sy_s3) <<< aff2d_pkg::FRAC_BITS;
				den_s4 <= det_s3;
			end else begin
				nx_s4  <= aff2d_pkg::NW'(sx_s3) + ox_fx;
				ny_s4  <= aff2d_pkg::NW'(sy_s3) + oy_fx;
				den_s4 <= aff2d_pkg::DEN_ONE;
			end
		end
		if (en[4]) begin
			unx_s5       <= nx_s4[aff2d_pkg::NW-1] ? aff2d_pkg::NW'(-nx_s4) : nx_s4;
			uny_s5       <= ny_s4[aff2d_pkg::NW-1] ? aff2d_pkg::NW'(-ny_s4) : ny_s4;
			ud_s5        <= den_s4[aff2d_pkg::DW-1] ? aff2d_pkg::DW'(-den_s4) : den_s4;
			tag_s5.neg_x <= nx_s4[aff2d_pkg::NW-1] ^ den_s4[aff2d_pkg::DW-1];
			tag_s5.neg_y <= ny_s4[aff2d_pkg::NW-1] ^ den_s4[aff2d_pkg::DW-1];
			tag_s5.sing  <= sing_s4 && inv_s4;
		end
	end

	assign un_x = unx_s5;
	assign un_y = uny_s5;
	assign ud   = ud_s5;
	assign tag  = tag_s5;

endmodule

[rtl/core/aff2d_div.sv]
`timescale 1ns / 1ps
// aff2d_div: pipelined restoring divider for both coordinates, one quotient bit per stage.
// Depends on aff2d_pkg. The top quotient bit set means the quotient is 2^32 or more.
module aff2d_div (
	input  logic                              clk,
	input  logic [aff2d_pkg::NDIV-1:0]        en,
	input  logic [aff2d_pkg::NW-1:0]          un_x,
	input  logic [aff2d_pkg::NW-1:0]          un_y,
	input  logic [aff2d_pkg::DW-1:0]          ud,
	input  aff2d_pkg::tag_t                   tag_in,
	output logic [aff2d_pkg::QW-1:0]          q_x,
	output logic [aff2d_pkg::QW-1:0]          q_y,
	output aff2d_pkg::tag_t                   tag_out
);

	logic [aff2d_pkg::RW-1:0] rx_sn [aff2d_pkg::NDIV];
	logic [aff2d_pkg::RW-1:0] ry_sn [aff2d_pkg::NDIV];
	logic [aff2d_pkg::QW-1:0] qx_sn [aff2d_pkg::NDIV];
	logic [aff2d_pkg::QW-1:0] qy_sn [aff2d_pkg::NDIV];
	logic [aff2d_pkg::DW-1:0] ud_sn [aff2d_pkg::NDIV];
	aff2d_pkg::tag_t          tag_sn [aff2d_pkg::NDIV];

	for (genvar j = 0; j < aff2d_pkg::NDIV; j++) begin : g_st
		localparam int B = aff2d_pkg::QW - 1 - j;

		logic [aff2d_pkg::RW-1:0] rx_i, ry_i, dsh, rx_n, ry_n;
		logic [aff2d_pkg::RW:0]   dfx, dfy;
		logic [aff2d_pkg::QW-1:0] qx_i, qy_i, qx_n, qy_n;
		logic [aff2d_pkg::DW-1:0] ud_i;
		aff2d_pkg::tag_t          tag_i;

		if (j == 0) begin : g_first
			assign rx_i  = aff2d_pkg::RW'(un_x);
			assign ry_i  = aff2d_pkg::RW'(un_y);
			assign qx_i  = '0;
			assign qy_i  = '0;
			assign ud_i  = ud;
			assign tag_i = tag_in;
		end else begin : g_next
			assign rx_i  = rx_sn[j-1];
			assign ry_i  = ry_sn[j-1];
			assign qx_i  = qx_sn[j-1];
			assign qy_i  = qy_sn[j-1];
			assign ud_i  = ud_sn[j-1];
			assign tag_i = tag_sn[j-1];
		end

		always_comb begin
			dsh  = aff2d_pkg::RW'(ud_i) << B;
			dfx  = {1'b0, rx_i} - {1'b0, dsh};
			dfy  = {1'b0, ry_i} - {1'b0, dsh};
			rx_n = dfx[aff2d_pkg::RW] ? rx_i : dfx[aff2d_pkg::RW-1:0];
			ry_n = dfy[aff2d_pkg::RW] ? ry_i : dfy[aff2d_pkg::RW-1:0];
			qx_n = qx_i;
			qy_n = qy_i;
			qx_n[B] = !dfx[aff2d_pkg::RW];
			qy_n[B] = !dfy[aff2d_pkg::RW];
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rx_sn[j]  <= rx_n;
				ry_sn[j]  <= ry_n;
				qx_sn[j]  <= qx_n;
				qy_sn[j]  <= qy_n;
				ud_sn[j]  <= ud_i;
				tag_sn[j] <= tag_i;
			end
		end
	end

	assign q_x     = qx_sn[aff2d_pkg::NDIV-1];
	assign q_y     = qy_sn[aff2d_pkg::NDIV-1];
	assign tag_out = tag_sn[aff2d_pkg::NDIV-1];

endmodule

[rtl/core/affine_2d_point_transform_core.sv]
`timescale 1ns / 1ps
// affine_2d_point_transform_core: top level, stage valid bits, saturation and output register.
// Depends on aff2d_pkg, aff2d_cfg, aff2d_front and aff2d_div.
//
// Transforms Q16.16 points by the 3x2 matrix (a, b, c, d, offset_x, offset_y).
// command 0 gives the forward transform, command 1 the inverse through the
// adjugate and the determinant; a zero determinant gives zero outputs and
// raises singular. Outputs are truncated toward zero and saturated.
// Input channel: in_valid / in_stall with command, x_in, y_in; a beat is taken
// when in_valid is high and in_stall low. Output channel: out_valid / out_stall
// with x_out, y_out, singular, saturated, taken the same way.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no beats are in flight.
// Throughput is one beat per clock while the output is not stalled. A beat passes through
// five front stages (offset subtract, multipliers, sums, scaling, magnitudes),
// 33 divider stages of one quotient bit each and the output register.
// Each stage has its own valid bit, so bubbles close up while the output is
// stalled and in_stall rises only when every stage holds a beat.
// Reset loads the identity matrix with zero offsets and empties the pipeline.
module affine_2d_point_transform_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [aff2d_pkg::IDXW-1:0]        cfg_index,
	input  logic [aff2d_pkg::CW-1:0]          cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic signed [aff2d_pkg::CW-1:0]   x_in,
	input  logic signed [aff2d_pkg::CW-1:0]   y_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [aff2d_pkg::CW-1:0]   x_out,
	output logic signed [aff2d_pkg::CW-1:0]   y_out,
	output logic                              singular,
	output logic                              saturated
);

	localparam int NST = aff2d_pkg::NST;

	aff2d_pkg::coef_t          coef;
	logic [NST-1:0]            vld_q;
	logic [NST:0]              load;
	logic [aff2d_pkg::NW-1:0]  un_x, un_y;
	logic [aff2d_pkg::DW-1:0]  ud;
	aff2d_pkg::tag_t           tag_f, tag_d;
	logic [aff2d_pkg::QW-1:0]  q_x, q_y;

	logic [aff2d_pkg::CW-1:0]  xv, yv;
	logic                      clip_x, clip_y;

	logic [aff2d_pkg::CW-1:0]  x_out_q, y_out_q;
	logic                      sing_q, sat_q;

	aff2d_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	aff2d_front u_front (
		.clk     (clk),
		.en      (load[aff2d_pkg::FRONT_ST-1:0]),
		.coef    (coef),
		.command (command),
		.x_in    (x_in),
		.y_in    (y_in),
		.un_x    (un_x),
		.un_y    (un_y),
		.ud      (ud),
		.tag     (tag_f)
	);

	aff2d_div u_div (
		.clk     (clk),
		.en      (load[aff2d_pkg::FRONT_ST +: aff2d_pkg::NDIV]),
		.un_x    (un_x),
		.un_y    (un_y),
		.ud      (ud),
		.tag_in  (tag_f),
		.q_x     (q_x),
		.q_y     (q_y),
		.tag_out (tag_d)
	);

	// a stage may load when the output drains or it or some later stage holds a bubble
	assign load[NST] = !out_stall;
	for (genvar k = 0; k < NST; k++) begin : g_load
		assign load[k] = !out_stall || !(&vld_q[NST-1:k]);
	end

	assign in_stall = !load[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (load[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// saturate the quotient magnitude with its sign
	always_comb begin
		clip_x = tag_d.neg_x ?
			(q_x[aff2d_pkg::QW-1] ||
				(q_x[aff2d_pkg::CW-1] && (|q_x[aff2d_pkg::CW-2:0]))) :
			(q_x[aff2d_pkg::QW-1] || q_x[aff2d_pkg::CW-1]);
		clip_y = tag_d.neg_y ?
			(q_y[aff2d_pkg::QW-1] ||
				(q_y[aff2d_pkg::CW-1] && (|q_y[aff2d_pkg::CW-2:0]))) :
			(q_y[aff2d_pkg::QW-1] || q_y[aff2d_pkg::CW-1]);
		if (clip_x) begin
			xv = tag_d.neg_x ? aff2d_pkg::SAT_MIN : aff2d_pkg::SAT_MAX;
		end else begin
			xv = tag_d.neg_x ? aff2d_pkg::CW'(~q_x[aff2d_pkg::CW-1:0] + aff2d_pkg::CW'(1)) :
				q_x[aff2d_pkg::CW-1:0];
		end
		if (clip_y) begin
			yv = tag_d.neg_y ? aff2d_pkg::SAT_MIN : aff2d_pkg::SAT_MAX;
		end else begin
			yv = tag_d.neg_y ? aff2d_pkg::CW'(~q_y[aff2d_pkg::CW-1:0] + aff2d_pkg::CW'(1)) :
				q_y[aff2d_pkg::CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load[NST-1]) begin
			if (tag_d.sing) begin
				x_out_q <= '0;
				y_out_q <= '0;
				sing_q  <= 1'b1;
				sat_q   <= 1'b0;
			end else begin
				x_out_q <= xv;
				y_out_q <= yv;
				sing_q  <= 1'b0;
				sat_q   <= clip_x || clip_y;
			end
		end
	end

	assign out_valid = vld_q[NST-1];
	assign x_out     = x_out_q;
	assign y_out     = y_out_q;
	assign singular  = sing_q;
	assign saturated = sat_q;

	// input is held back only when the whole pipeline is full behind a stalled beat
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && (&vld_q)))
		else $error("input stalled with room in the pipeline");

	// a singular beat carries zero coordinates and no clip
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && singular) |-> (x_out == '0 && y_out == '0 && !saturated))
		else $error("singular beat with non-zero payload");

	// a clipped beat has at least one coordinate at a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
			(x_out == aff2d_pkg::SAT_MAX || x_out == aff2d_pkg::SAT_MIN ||
			 y_out == aff2d_pkg::SAT_MAX || y_out == aff2d_pkg::SAT_MIN))
		else $error("saturated beat without a limit value");

	// a beat taken at the output leaves the last stage empty unless one moves up behind it
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !vld_q[NST-2]) |=> !out_valid)
		else $error("output beat repeated");

endmodule

[tb/sv/affine_2d_point_transform_core_test.sv]
`timescale 1ns / 1ps
// affine_2d_point_transform_core_test: self-checking bench for the 2d affine point transform.
// Depends on aff2d_pkg and affine_2d_point_transform_core; predicts in 128-bit arithmetic.
module affine_2d_point_transform_core_test;

	localparam logic [aff2d_pkg::IDXW-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [aff2d_pkg::IDXW-1:0] REG_SPARE_7 = 3'd7;
	localparam logic            CMD_FWD     = 1'b0;
	localparam logic            CMD_INV     = 1'b1;
	localparam int              WDOG_LIMIT  = 5000;
	localparam int              LONG_HOLD   = 300;

	typedef struct packed {
		logic signed [aff2d_pkg::CW-1:0] x;
		logic signed [aff2d_pkg::CW-1:0] y;
		logic                 sing;
		logic                 sat;
	} point_res_t;

	logic                 clk, arst_n;
	logic                 cfg_valid, cfg_ready;
	logic [aff2d_pkg::IDXW-1:0]      cfg_index;
	logic [aff2d_pkg::CW-1:0]        cfg_data;
	logic                 in_valid, in_stall, command;
	logic signed [aff2d_pkg::CW-1:0] x_in, y_in;
	logic                 out_valid, out_stall;
	logic signed [aff2d_pkg::CW-1:0] x_out, y_out;
	logic                 singular, saturated;

	affine_2d_point_transform_core DUT (.*);

	// bench copy of the matrix registers
	logic signed [aff2d_pkg::CW-1:0] m_a, m_b, m_c, m_d, m_ox, m_oy;
	point_res_t           pending_pts[$];
	int                   errors, n_checked, n_sing, n_sat, n_sent, n_cfg;
	bit                   tx_idle_en, rx_idle_en, hold_req;
	int                   quiet_cycles;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic logic [aff2d_pkg::CW-1:0] clip32(input logic signed [127:0] v,
			inout logic sat);
		if (v > 128'sh7FFFFFFF) begin
			sat = 1'b1;
			return aff2d_pkg::SAT_MAX;
		end
		if (v < -128'sh80000000) begin
			sat = 1'b1;
			return aff2d_pkg::SAT_MIN;
		end
		return v[aff2d_pkg::CW-1:0];
	endfunction

	function automatic point_res_t transform_point(logic cmd,
			logic signed [aff2d_pkg::CW-1:0] x, logic signed [aff2d_pkg::CW-1:0] y);
		logic signed [127:0] nx, ny, den, dx, dy;
		point_res_t r;
		r = '0;
		if (cmd == CMD_FWD) begin
			nx = m_a * x + m_c * y + (128'(m_ox) <<< aff2d_pkg::FRAC_BITS);
			ny = m_b * x + m_d * y + (128'(m_oy) <<< aff2d_pkg::FRAC_BITS);
			den = 128'sd1 <<< aff2d_pkg::FRAC_BITS;
		end else begin
			dx = x - m_ox;
			dy = y - m_oy;
			den = m_a * m_d - m_c * m_b;
			if (den == 0) begin
				r.sing = 1'b1;
				return r;
			end
			nx = (dx * m_d - dy * m_c) <<< aff2d_pkg::FRAC_BITS;
			ny = (dy * m_a - dx * m_b) <<< aff2d_pkg::FRAC_BITS;
		end
		// signed division truncates toward zero
		r.x = clip32(nx / den, r.sat);
		r.y = clip32(ny / den, r.sat);
		return r;
	endfunction

	task automatic send_point(logic cmd, logic signed [aff2d_pkg::CW-1:0] x,
			logic signed [aff2d_pkg::CW-1:0] y);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		x_in     <= x;
		y_in     <= y;
		do @(posedge clk); while (in_stall);
		pending_pts.push_back(transform_point(cmd, x, y));
		n_sent++;
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		wait (pending_pts.size() == 0);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [aff2d_pkg::IDXW-1:0] idx,
			logic signed [aff2d_pkg::CW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			aff2d_pkg::REG_COEF_A:   m_a  = val;
			aff2d_pkg::REG_COEF_B:   m_b  = val;
			aff2d_pkg::REG_COEF_C:   m_c  = val;
			aff2d_pkg::REG_COEF_D:   m_d  = val;
			aff2d_pkg::REG_OFFSET_X: m_ox = val;
			aff2d_pkg::REG_OFFSET_Y: m_oy = val;
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic load_matrix(logic signed [aff2d_pkg::CW-1:0] a, b, c, d, ox, oy);
		write_reg(aff2d_pkg::REG_COEF_A, a);
		write_reg(aff2d_pkg::REG_COEF_B, b);
		write_reg(aff2d_pkg::REG_COEF_C, c);
		write_reg(aff2d_pkg::REG_COEF_D, d);
		write_reg(aff2d_pkg::REG_OFFSET_X, ox);
		write_reg(aff2d_pkg::REG_OFFSET_Y, oy);
	endtask

	function automatic logic [aff2d_pkg::CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? aff2d_pkg::SAT_MAX : aff2d_pkg::SAT_MIN;
			1: return $urandom;
			2: return $signed(aff2d_pkg::CW'($urandom_range(0, 'h7FFF))) <<<
				$urandom_range(0, 16);
			default: return $signed(aff2d_pkg::CW'($urandom_range(0, 'h3FFFFF))) - 'sh200000;
		endcase
	endfunction

	function automatic logic [aff2d_pkg::CW-1:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? aff2d_pkg::SAT_MAX : aff2d_pkg::SAT_MIN;
			default: return $signed(aff2d_pkg::CW'($urandom_range(0, 'h3FFFF))) - 'sh1FFFF;
		endcase
	endfunction

	task automatic send_random(int n);
		repeat (n) send_point(logic'($urandom_range(0, 1)), rand_coord(), rand_coord());
	endtask

	task automatic test_identity_extremes();
		logic signed [aff2d_pkg::CW-1:0] pts[6] =
			'{aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN, 0, 1, -1, 'sh10000};
		foreach (pts[i]) begin
			send_point(CMD_FWD, pts[i], pts[5 - i]);
			send_point(CMD_INV, pts[5 - i], pts[i]);
		end
		end_burst();
	endtask

	task automatic test_register_extremes();
		load_matrix(aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN, aff2d_pkg::SAT_MIN,
			aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN);
		send_point(CMD_FWD, aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MAX);
		send_point(CMD_INV, aff2d_pkg::SAT_MIN, aff2d_pkg::SAT_MAX);
		send_point(CMD_FWD, 0, 0);
		send_point(CMD_INV, 'sh12345, -'sh777);
		end_burst();
		// spare indexes must leave the matrix alone
		write_reg(REG_SPARE_6, $urandom);
		write_reg(REG_SPARE_7, $urandom);
		send_point(CMD_FWD, 'sh30000, -'sh20000);
		send_point(CMD_INV, aff2d_pkg::SAT_MIN, aff2d_pkg::SAT_MIN);
		end_burst();
	endtask

	task automatic test_singular();
		logic signed [aff2d_pkg::CW-1:0] k;
		k = rand_coef();
		load_matrix(k, k, -'sh30000, -'sh30000, 'sh1000, -'sh1000);
		send_point(CMD_INV, 'sh10000, 'sh20000);
		send_point(CMD_FWD, 'sh10000, 'sh20000);
		send_point(CMD_INV, aff2d_pkg::SAT_MAX, aff2d_pkg::SAT_MIN);
		end_burst();
		load_matrix(0, 0, 0, 0, 0, 0);
		send_random(6);
		end_burst();
	endtask

	task automatic test_random_matrices();
		for (int ph = 0; ph < 12; ph++) begin
			if (ph % 4 == 3) begin
				logic signed [aff2d_pkg::CW-1:0] k;
				k = rand_coef();
				load_matrix(k, rand_coef(), k, rand_coef(), rand_coord(), rand_coord());
				write_reg(aff2d_pkg::REG_COEF_B, m_a);
				write_reg(aff2d_pkg::REG_COEF_D, m_c);
			end else begin
				load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_coord(), rand_coord());
			end
			send_random(130);
			end_burst();
		end
	endtask

	task automatic test_backpressure();
		load_matrix('sh18000, -'sh4000, 'sh2000, 'sh8000, 'sh50000, -'sh30000);
		hold_req = 1'b1;
		send_random(150);
		end_burst();
	endtask

	task automatic test_full_rate();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
			rand_coord(), rand_coord());
		send_random(100);
		end_burst();
	endtask

	// output side stall, random bursts or one long hold
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		point_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pts.size() == 0) begin
				$display("%0t: unexpected beat x=%h y=%h", $time, x_out, y_out);
				errors++;
			end else begin
				want = pending_pts.pop_front();
				n_checked++;
				if (want.sing) n_sing++;
				if (want.sat) n_sat++;
				if (x_out !== want.x) begin
					$display("%0t: x_out expected %h got %h", $time, want.x, x_out);
					errors++;
				end
				if (y_out !== want.y) begin
					$display("%0t: y_out expected %h got %h", $time, want.y, y_out);
					errors++;
				end
				if (singular !== want.sing) begin
					$display("%0t: singular expected %b got %b", $time, want.sing, singular);
					errors++;
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated expected %b got %b", $time, want.sat, saturated);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with work outstanding but no beat moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid
				|| (pending_pts.size() == 0 && !in_valid)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; command = CMD_FWD; x_in = '0; y_in = '0;
		errors = 0; n_checked = 0; n_sing = 0; n_sat = 0; n_sent = 0; n_cfg = 0;
		quiet_cycles = 0; hold_req = 1'b0;
		tx_idle_en = 1'b1; rx_idle_en = 1'b1;
		m_a = aff2d_pkg::COEF_ONE; m_b = 0; m_c = 0; m_d = aff2d_pkg::COEF_ONE;
		m_ox = 0; m_oy = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_extremes();
		test_register_extremes();
		test_singular();
		test_random_matrices();
		test_backpressure();
		test_full_rate();
		$display("%0d points sent, %0d checked (%0d singular, %0d clipped), %0d register writes",
			n_sent, n_checked, n_sing, n_sat, n_cfg);
		$display("covered forward and inverse, extreme and random matrices, long output hold");
		if (errors == 0 && pending_pts.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
